// ----- hw/rtl/pmu_pkg.sv -----
// ----------------------------------------------------------------------------
// pmu_pkg: shared types and constants for the Piola mapping unit
// Request codes, mode codes, register indexes and the item structs.
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [2:0] {
    REQ_LOAD_J   = 3'd0,
    REQ_LOAD_K   = 3'd1,
    REQ_LOAD_DET = 3'd2,
    REQ_LOAD_DAT = 3'd3,
    REQ_COMPUTE  = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    MODE_IDENT  = 3'd0,
    MODE_COV    = 3'd1,
    MODE_CONTRA = 3'd2,
    MODE_DCOV   = 3'd3,
    MODE_DCON   = 3'd4
  } map_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_MODE = 2'd0,
    REG_GEO_DIM  = 2'd1,
    REG_TOPO_DIM = 2'd2,
    REG_ID_SIZE  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mapped_value;
    logic [3:0]         out_index;
    logic               last_flag;
    logic               error_code;
  } out_item_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/pmu_front.sv -----
// ----------------------------------------------------------------------------
// pmu_front: item intake
// Accept items, drop unused codes and push them into the command queue.
// ----------------------------------------------------------------------------
module pmu_front #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmu_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pmu_pkg::in_item_t item_o
);
  localparam int unsigned AW = $clog2(Depth);

  pmu_pkg::in_item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          keep;

  assign keep    = push_i && (item_i.req_type <= pmu_pkg::REQ_COMPUTE);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (keep) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (keep) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(keep) - (AW+1)'(pop_i);
    end
  end
endmodule

// ----- hw/rtl/pmu_div.sv -----
// ----------------------------------------------------------------------------
// pmu_div: fixed-point divider
// Compute round((x << FRAC) / d), ties away from zero, one bit a cycle.
// ----------------------------------------------------------------------------
module pmu_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] d_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  localparam int unsigned NW = 32 + FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [32:0]   den_q;
  logic [33:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, run_q, done_q;
  logic [33:0]   sh, sub;
  logic [63:0]   qfull;
  logic [32:0]   half;
  logic signed [63:0] sq;

  assign sh  = {rem_q[32:0], num_q[NW-1]};
  assign sub = sh - {1'b0, den_q};
  // num_q collects quotient bits; remainder decides rounding
  assign half = den_q >> 1;
  always_comb begin
    qfull = 64'(num_q);
    if ({1'b0, rem_q[32:0]} >= {1'b0, den_q} - {1'b0, half}) qfull = qfull + 64'd1;
    if (qfull > 64'h80000000) qfull = 64'h80000000;
    sq = neg_q ? -$signed(qfull) : $signed(qfull);
  end
  assign q_o    = pmu_pkg::sat32(sq);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1; cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0; done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NW'({x_i[31] ? -{1'b0, x_i} : {1'b0, x_i}, FracBits'(0)});
      den_q <= d_i[31] ? -{d_i[31], d_i} : {1'b0, d_i};
      rem_q <= '0;
      neg_q <= x_i[31] ^ d_i[31];
    end else if (run_q) begin
      if (!sub[33]) begin
        rem_q <= sub; num_q <= {num_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= sh;  num_q <= {num_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- hw/rtl/pmu_back.sv -----
// ----------------------------------------------------------------------------
// pmu_back: load and compute engine
// Hold the stores, run the multiply-accumulates and emit results; a new item is taken only while idle.
// ----------------------------------------------------------------------------
module pmu_back #(
  parameter int unsigned MaxDim   = 3,
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  pmu_pkg::in_item_t  item_i,
  output logic               pop_o,
  input  logic [2:0]         map_mode_i,
  input  logic [1:0]         geo_dim_i,
  input  logic [1:0]         topo_dim_i,
  input  logic [3:0]         identity_size_i,
  output logic               idle_o,
  output logic               res_valid_o,
  output pmu_pkg::out_item_t res_o
);
  localparam int unsigned NEnt = MaxDim * MaxDim;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL  = 7'b0000010, S_ACC = 7'b0000100,
    S_FIN  = 7'b0001000, S_DIV1 = 7'b0010000, S_DIV2 = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  logic signed [31:0] jac_q [NEnt];
  logic signed [31:0] inv_q [NEnt];
  logic signed [31:0] dat_q [NEnt];
  logic signed [31:0] tmp_q [NEnt];
  logic signed [31:0] det_q;

  state_e state_q;
  logic [2:0] mode_q;
  logic [1:0] g_q, t_q;
  logic [3:0] cnt_q;
  logic [1:0] i_q, j_q, a_q;
  logic       pass_q, err_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] val_q, ma, mb;
  logic [1:0] gd, td;
  logic [3:0] ids;
  logic ld_ok;
  logic div_start, div_done;
  logic signed [31:0] div_x, div_q;
  logic signed [63:0] rnd;
  logic signed [31:0] mq;

  function automatic logic [3:0] ix(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) + 4'(c) * 4'(MaxDim);
  endfunction

  assign gd  = (geo_dim_i == 0) ? 2'd1 : ((32'(geo_dim_i) > MaxDim) ? 2'(MaxDim) : geo_dim_i);
  assign td  = (topo_dim_i == 0) ? 2'd1 : ((32'(topo_dim_i) > MaxDim) ? 2'(MaxDim) : topo_dim_i);
  assign ids = (identity_size_i == 0) ? 4'd1
             : ((32'(identity_size_i) > NEnt) ? 4'(NEnt) : identity_size_i);
  assign ld_ok = (32'(item_i.row_index) < MaxDim) && (32'(item_i.col_index) < MaxDim);
  assign idle_o = (state_q == S_IDLE) && empty_i;
  assign pop_o  = (state_q == S_IDLE) && !empty_i;

  // operand select: first pass A*M, second pass tmp*B
  always_comb begin
    ma = '0; mb = '0;
    if (mode_q == pmu_pkg::MODE_COV || mode_q == pmu_pkg::MODE_DCOV) begin
      ma = pass_q ? tmp_q[ix(i_q, a_q)] : inv_q[ix(a_q, i_q)];
      mb = pass_q ? inv_q[ix(a_q, j_q)] : dat_q[ix(a_q, j_q)];
    end else begin
      ma = pass_q ? tmp_q[ix(i_q, a_q)] : jac_q[ix(i_q, a_q)];
      mb = pass_q ? jac_q[ix(j_q, a_q)] : dat_q[ix(a_q, j_q)];
    end
  end

  // round half up and saturate the registered product
  assign rnd = (prod_q + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  assign mq  = pmu_pkg::sat32(rnd);

  // val_q holds the saturated sum, then the first quotient
  assign div_x = val_q;
  pmu_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .x_i(div_x), .d_i(det_q),
    .done_o(div_done), .q_o(div_q)
  );

  logic div_busy_q;
  assign div_start = (state_q == S_DIV1 || state_q == S_DIV2) && !div_busy_q;

  always_ff @(posedge clk_i) begin
    if (pop_o && ld_ok) begin
      case (item_i.req_type)
        pmu_pkg::REQ_LOAD_J:   jac_q[ix(item_i.row_index, item_i.col_index)] <= item_i.elem_value;
        pmu_pkg::REQ_LOAD_K:   inv_q[ix(item_i.row_index, item_i.col_index)] <= item_i.elem_value;
        pmu_pkg::REQ_LOAD_DAT: dat_q[ix(item_i.row_index, item_i.col_index)] <= item_i.elem_value;
        default: ;
      endcase
    end
    if (pop_o && item_i.req_type == pmu_pkg::REQ_LOAD_DET) det_q <= item_i.elem_value;
    prod_q <= 64'(ma) * 64'(mb);
    if (state_q == S_FIN && !pass_q && (mode_q == pmu_pkg::MODE_DCOV || mode_q == pmu_pkg::MODE_DCON))
      tmp_q[ix(i_q, j_q)] <= pmu_pkg::sat32(acc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; res_valid_o <= 1'b0; res_o <= '0;
      mode_q <= '0; g_q <= 2'd1; t_q <= 2'd1; cnt_q <= '0;
      i_q <= '0; j_q <= '0; a_q <= '0; pass_q <= 1'b0; err_q <= 1'b0;
      acc_q <= '0; val_q <= '0; div_busy_q <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_o && item_i.req_type == pmu_pkg::REQ_COMPUTE) begin
            mode_q <= map_mode_i; g_q <= gd; t_q <= td;
            i_q <= '0; j_q <= '0; a_q <= '0; pass_q <= 1'b0; acc_q <= '0;
            err_q <= (map_mode_i == pmu_pkg::MODE_CONTRA || map_mode_i == pmu_pkg::MODE_DCON)
                     && det_q == 0;
            if (map_mode_i == pmu_pkg::MODE_IDENT) begin
              cnt_q <= ids; state_q <= S_EMIT;
            end else if (map_mode_i <= pmu_pkg::MODE_DCON) begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          acc_q <= acc_q + 64'(mq);
          if (a_q == t_q - 2'd1) state_q <= S_FIN;
          else begin a_q <= a_q + 2'd1; state_q <= S_MUL; end
        end
        S_FIN: begin
          a_q <= '0; acc_q <= '0;
          if (!pass_q && (mode_q == pmu_pkg::MODE_DCOV || mode_q == pmu_pkg::MODE_DCON)) begin
            // walk tmp (g x t), then the second product over g x g
            state_q <= S_MUL;
            if (j_q == t_q - 2'd1) begin
              j_q <= '0;
              if (i_q == g_q - 2'd1) begin i_q <= '0; pass_q <= 1'b1; end
              else i_q <= i_q + 2'd1;
            end else j_q <= j_q + 2'd1;
          end else begin
            val_q <= err_q ? '0 : pmu_pkg::sat32(acc_q);
            if (!err_q && (mode_q == pmu_pkg::MODE_CONTRA || mode_q == pmu_pkg::MODE_DCON))
              state_q <= S_DIV1;
            else state_q <= S_EMIT;
          end
        end
        S_DIV1, S_DIV2: begin
          if (!div_busy_q) div_busy_q <= 1'b1;
          else if (div_done) begin
            div_busy_q <= 1'b0; val_q <= div_q;
            state_q <= (state_q == S_DIV1 && mode_q == pmu_pkg::MODE_DCON) ? S_DIV2 : S_EMIT;
          end
        end
        S_EMIT: begin
          res_valid_o <= 1'b1;
          res_o.error_code <= err_q;
          if (mode_q == pmu_pkg::MODE_IDENT) begin
            res_o.mapped_value <= dat_q[ix(a_q, j_q)];
            res_o.out_index <= ix(a_q, j_q);
            res_o.last_flag <= (ix(a_q, j_q) == cnt_q - 4'd1);
            if (ix(a_q, j_q) == cnt_q - 4'd1) state_q <= S_IDLE;
            else if (32'(a_q) == MaxDim - 1) begin a_q <= '0; j_q <= j_q + 2'd1; end
            else a_q <= a_q + 2'd1;
          end else if (!pass_q) begin
            res_o.mapped_value <= val_q;
            res_o.out_index <= {2'b0, i_q};
            res_o.last_flag <= (i_q == g_q - 2'd1);
            if (i_q == g_q - 2'd1) state_q <= S_IDLE;
            else begin i_q <= i_q + 2'd1; state_q <= S_MUL; end
          end else begin
            res_o.mapped_value <= val_q;
            res_o.out_index <= 4'(i_q) + 4'(j_q) * 4'(g_q);
            res_o.last_flag <= (i_q == g_q - 2'd1) && (j_q == g_q - 2'd1);
            state_q <= S_MUL;
            if (i_q == g_q - 2'd1) begin
              i_q <= '0;
              if (j_q == g_q - 2'd1) state_q <= S_IDLE;
              else j_q <= j_q + 2'd1;
            end else i_q <= i_q + 2'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/piola_mapping_unit_core.sv -----
// ----------------------------------------------------------------------------
// piola_mapping_unit_core: Piola push-forward of reference data
// Top level: registers, intake queue and compute engine.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on item_i with start high; it is taken at the rising edge
//   at which busy is low. Load items (J, K, determinant, data) go into the
//   stores; a compute item emits the mapped run, one item per result_valid_o
//   pulse, column-major, last_flag on the final one. Results cannot be held off.
//   Loads flow every cycle while the engine is idle; a compute run holds them
//   back. Identity emits one item a cycle. Any other mapped element runs
//   topo_dim multiply-accumulates (a multiply and an accumulate step each),
//   then a finish and an emit step; the double mappings first build each
//   element of the geo x topo intermediate with its multiply-accumulates and
//   a finish step (up to 54 multiply-accumulates in all). Each division by the
//   determinant adds a start, FracBits + 32 quotient steps and a hand-off;
//   double contravariant divides twice. A four-entry queue parts intake from
//   the engine; busy rises when the queue fills. Reset clears the control
//   state and the registers to mode identity, dimensions 3 and identity size
//   1; stores are undefined until loaded. Write cfg registers only while
//   idle_o is high.
// ----------------------------------------------------------------------------
module piola_mapping_unit_core #(
  parameter int unsigned MaxDim   = 3,
  parameter int unsigned FracBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  pmu_pkg::in_item_t              item_i,
  input  logic                           cfg_we_i,
  input  logic [pmu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pmu_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           idle_o,
  output logic                           result_valid_o,
  output pmu_pkg::out_item_t             result_o
);
  logic [2:0] mode_q;
  logic [1:0] geo_q, topo_q;
  logic [3:0] ids_q;
  logic       full, empty, pop;
  pmu_pkg::in_item_t head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; geo_q <= 2'd3; topo_q <= 2'd3; ids_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmu_pkg::REG_MAP_MODE: mode_q <= cfg_data_i[2:0];
        pmu_pkg::REG_GEO_DIM:  geo_q  <= cfg_data_i[1:0];
        pmu_pkg::REG_TOPO_DIM: topo_q <= cfg_data_i[1:0];
        pmu_pkg::REG_ID_SIZE:  ids_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = full;

  pmu_front #(.Depth(4)) u_front (
    .clk_i, .rst_ni, .push_i(start && !full), .item_i, .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(head)
  );

  pmu_back #(.MaxDim(MaxDim), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(head), .pop_o(pop),
    .map_mode_i(mode_q), .geo_dim_i(geo_q), .topo_dim_i(topo_q),
    .identity_size_i(ids_q), .idle_o, .res_valid_o(result_valid_o),
    .res_o(result_o)
  );
endmodule
